[rtl/core/rolling_window_sum_or_mean_assert.svh]
// Assertion helpers for the rolling window block.
`ifndef ROLLING_WINDOW_SUM_OR_MEAN_ASSERT_SVH
`define ROLLING_WINDOW_SUM_OR_MEAN_ASSERT_SVH

// Same-cycle implication.
`define RWSM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RWSM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rwsm_pkg.sv]
package rwsm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int OUT_W      = 38;
  localparam int LEN_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 4'd1;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd4;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic load;
    logic read;
    logic update;
    logic div_load;
    logic div_step;
    logic fin_load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic mode;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/rwsm_if.sv]
interface rwsm_smp_if import rwsm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface rwsm_res_if import rwsm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] window_value;

  modport source (output valid, output window_value, input ready);
  modport sink (input valid, input window_value, output ready);
endinterface

interface rwsm_cfg_if import rwsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/rolling_window_sum_or_mean.sv]
// Channel   Role    Payload
// samples   sink    sample (s32 Q16.16), start_req
// results   source  window_value (s38 Q22.16)
// cfg       sink    index, data (0: window_len, 1: mode)
//
// Sum mode: each word steps through accept, RAM read, update, result load; with no result the load is skipped.
// Mean mode adds the bit-serial divider steps between update and result load.
// Reset: window empty, window_len 4, mode 0; the delay line is not cleared.
// A result waiting on results holds in its register; the next sample is taken
//   meanwhile, only the following result load waits for it to drain.
// cfg is always ready.
`include "rolling_window_sum_or_mean_assert.svh"

module rolling_window_sum_or_mean import rwsm_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic           clk,
  input  logic           rst,
  rwsm_smp_if.sink       samples,
  rwsm_res_if.source     results,
  rwsm_cfg_if.sink       cfg
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  rwsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rwsm_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (samples.sample),
    .start_req (samples.start_req),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_data  (results.window_value)
  );

  assign samples.ready = in_ready;
  assign cfg.ready     = 1'b1;

  `RWSM_ASSERT_NEXT(a_one_word, clk, rst, samples.valid && samples.ready, !samples.ready, "word accepted while busy")
  `RWSM_ASSERT_IMPL(a_read_first, clk, rst, cmd.update, $past(cmd.read), "update without RAM read")
  `RWSM_ASSERT_IMPL(a_res_src, clk, rst, $rose(results.valid), $past(cmd.fin_load), "result valid without load")

endmodule

[rtl/core/rwsm_ram.sv]
module rwsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/rwsm_ctrl.sv]
module rwsm_ctrl import rwsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (!sts.emit) state_next = S_IDLE;
        else if (sts.mode) state_next = S_DIV;
        else state_next = S_FIN;
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready     = (state == S_IDLE);
  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.read     = (state == S_READ);
  assign cmd.update   = (state == S_UPD);
  assign cmd.div_load = (state == S_UPD) && sts.emit && sts.mode;
  assign cmd.div_step = (state == S_DIV);
  assign cmd.fin_load = (state == S_FIN) && sts.out_free;

endmodule

[rtl/core/rwsm_dp.sv]
module rwsm_dp import rwsm_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  output dp_sts_t                      sts,
  input  logic signed [SAMPLE_W-1:0]   sample,
  input  logic                         start_req,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_W-1:0]      out_data
);

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int IW    = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int CW    = $clog2(SUM_W + 1);

  logic [LEN_W-1:0]          window_len;
  logic                      mode;
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [SUM_W-1:0]   total;
  logic [LEN_W-1:0]          fill;
  logic [AW-1:0]             slot;
  logic [SUM_W-1:0]          quo;
  logic [LEN_W-1:0]          rem;
  logic                      neg;
  logic [CW-1:0]             dcnt;

  logic [LEN_W-1:0]          eff_len;
  logic                      full;
  logic [IW-1:0]             slot_ext;
  logic [IW-1:0]             len_ext;
  logic [IW-1:0]             old_ext;
  logic [AW-1:0]             slot_next;
  logic [SAMPLE_W-1:0]       rd_data;
  logic signed [SUM_W-1:0]   old_term;
  logic signed [SUM_W-1:0]   total_next;
  logic [SUM_W-1:0]          total_abs;
  logic [LEN_W:0]            trial;
  logic                      trial_ge;
  logic signed [SUM_W-1:0]   mean;
  logic signed [SUM_W-1:0]   src;
  logic signed [OUT_W-1:0]   sat;

  always_comb begin
    if (window_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = window_len;
    end
  end

  assign full     = (fill >= eff_len);
  assign slot_ext = IW'(slot);
  assign len_ext  = IW'(eff_len);
  assign old_ext  = (slot_ext >= len_ext) ? (slot_ext - len_ext)
                                          : (slot_ext + IW'(MAX_WINDOW) - len_ext);
  assign slot_next = (slot == AW'(MAX_WINDOW - 1)) ? '0 : slot + 1'b1;

  rwsm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_line (
    .clk     (clk),
    .wr_en   (cmd.update),
    .wr_addr (slot),
    .wr_data (smp),
    .rd_en   (cmd.read),
    .rd_addr (old_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  assign old_term   = full ? SUM_W'($signed(rd_data)) : '0;
  assign total_next = total - old_term + SUM_W'(smp);
  assign total_abs  = total_next[SUM_W-1] ? SUM_W'(-total_next) : SUM_W'(total_next);

  // restoring divide, one quotient bit per cycle
  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, eff_len});

  assign mean = neg ? -$signed(quo) : $signed(quo);
  assign src  = mode ? mean : total;

  generate
    if (SUM_W > OUT_W) begin : g_sat
      logic hi_same;
      assign hi_same = (&src[SUM_W-1:OUT_W-1]) | ~(|src[SUM_W-1:OUT_W-1]);
      assign sat = hi_same ? src[OUT_W-1:0] : (src[SUM_W-1] ? OUT_MIN : OUT_MAX);
    end else begin : g_ext
      assign sat = OUT_W'(src);
    end
  endgenerate

  assign sts.emit     = full || ((fill + 7'd1) == eff_len);
  assign sts.mode     = mode;
  assign sts.div_done = (dcnt == '0);
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_RESET;
      mode       <= 1'b0;
      total      <= '0;
      fill       <= '0;
      slot       <= '0;
      dcnt       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len <= cfg_data[LEN_W-1:0];
            total      <= '0;
            fill       <= '0;
            slot       <= '0;
          end
          REG_MODE: begin
            mode <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (cmd.load && start_req) begin
        total <= '0;
        fill  <= '0;
        slot  <= '0;
      end
      if (cmd.update) begin
        total <= total_next;
        slot  <= slot_next;
        if (!full) fill <= fill + 7'd1;
      end
      if (cmd.div_load) begin
        dcnt <= CW'(SUM_W);
      end else if (cmd.div_step && dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
      end
      if (cmd.fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample;
    end
    if (cmd.div_load) begin
      quo <= total_abs;
      rem <= '0;
      neg <= total_next[SUM_W-1];
    end else if (cmd.div_step && dcnt != '0) begin
      quo <= {quo[SUM_W-2:0], trial_ge};
      rem <= trial_ge ? LEN_W'(trial - {1'b0, eff_len}) : trial[LEN_W-1:0];
    end
    if (cmd.fin_load) begin
      out_data <= sat;
    end
  end

endmodule
